// ===== rtl/bam_pkg.sv =====
// Shared constants, command codes and types for the allocation bit map.
package bam_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int WORD_BITS   = 32;
	localparam int OFF_W       = 5;
	localparam int WORDS       = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
	// wide enough for a word base plus one word, and for the 11-bit count
	localparam int BASE_W      = (WADDR_W + OFF_W + 1 > 12) ? (WADDR_W + OFF_W + 1) : 12;
	localparam int CNT_CAP     = (MAX_ENTRIES > 2047) ? 2047 : MAX_ENTRIES;

	localparam logic [2:0] CMD_SET_ALL = 3'd0;
	localparam logic [2:0] CMD_CLR_ALL = 3'd1;
	localparam logic [2:0] CMD_SET_ONE = 3'd2;
	localparam logic [2:0] CMD_CLR_ONE = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;
	localparam logic [2:0] CMD_FIND    = 3'd5;

	typedef struct packed {
		logic [WORD_BITS-1:0] set_word;
		logic [WORD_BITS-1:0] clr_word;
		logic                 bit_val;
		logic                 zero_hit;
		logic [OFF_W-1:0]     zero_pos;
	} wu_res_t;

endpackage

// ===== rtl/bam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bam_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                            rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bam_word_unit.sv =====
// Shared word unit: bit update, bit read and lowest-clear search over one word.
module bam_word_unit (
	input  logic [bam_pkg::WORD_BITS-1:0] word,
	input  logic [bam_pkg::OFF_W-1:0]     off,
	input  logic [bam_pkg::OFF_W:0]       lim,
	output bam_pkg::wu_res_t              res
);

	logic [bam_pkg::WORD_BITS-1:0] one_hot;
	logic [bam_pkg::WORD_BITS-1:0] valid_mask;
	logic [bam_pkg::WORD_BITS-1:0] masked;

	always_comb begin
		one_hot = bam_pkg::WORD_BITS'(1) << off;
		if (lim >= (bam_pkg::OFF_W + 1)'(bam_pkg::WORD_BITS)) begin
			valid_mask = '1;
		end else begin
			valid_mask = (bam_pkg::WORD_BITS'(1) << lim) - bam_pkg::WORD_BITS'(1);
		end
		// bits past the count look set so the search skips them
		masked       = word | ~valid_mask;
		res.set_word = word | one_hot;
		res.clr_word = word & ~one_hot;
		res.bit_val  = word[off];
		res.zero_hit = ~&masked;
		res.zero_pos = '0;
		for (int i = bam_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!masked[i]) begin
				res.zero_pos = bam_pkg::OFF_W'(i);
			end
		end
	end

endmodule

// ===== rtl/bitmap_allocation_map.sv =====
// Allocation bit map top level: sequencer, register port and result register.
//
// Input channel (command, index) and result channel (bit_value, free_found,
// free_index, index_valid) use valid/stall; one result per input transaction.
// The marks live in a 32-word x 32-bit RAM that is worked one word per
// cycle through a shared word unit. Set all and clear all write one RAM
// word per cycle; find reads the words from the lowest one up.
// The RAM's single read port sets the find time; the write port sets the
// set all / clear all time. One transaction is worked at a time: in_stall is
// high from accept until the result is loaded into the output register.
// After reset the block clears the RAM with in_stall high; the count
// register resets to 1024 and is written through the APB port.
// A stalled result holds in the output register; the next transaction may be
// accepted and worked meanwhile, and its result waits until the register frees.
module bitmap_allocation_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        bit_value,
	output logic        free_found,
	output logic [10:0] free_index,
	output logic        index_valid
);

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WORD = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int BW = bam_pkg::BASE_W;
	localparam int AW = bam_pkg::WADDR_W;

	logic [2:0]                      state_q;
	logic [10:0]                     ec_q;
	logic [2:0]                      cmd_q;
	logic [bam_pkg::OFF_W-1:0]       off_q;
	logic [AW-1:0]                   waddr_q;
	logic [AW-1:0]                   scan_q;
	logic                            valid_q;
	logic                            fill_val_q;
	logic                            fill_res_q;
	logic                            res_bit_q;
	logic                            res_found_q;
	logic [10:0]                     res_idx_q;
	logic                            out_valid_q;
	logic                            out_bit_q;
	logic                            out_found_q;
	logic [10:0]                     out_idx_q;
	logic                            out_ivalid_q;

	logic [10:0]                     cnt;
	logic                            acc;
	logic                            in_ok;
	logic                            load_out;
	logic [AW-1:0]                   in_word;
	logic [AW-1:0]                   raddr;
	logic [AW-1:0]                   waddr;
	logic [bam_pkg::WORD_BITS-1:0]   wdata;
	logic                            we;
	logic [bam_pkg::WORD_BITS-1:0]   rdata;
	logic [BW-1:0]                   base;
	logic [BW-1:0]                   cnt_x;
	logic [BW-1:0]                   rem;
	logic [bam_pkg::OFF_W:0]         lim;
	logic                            scan_last;
	logic [10:0]                     hit_idx;
	logic                            cfg_we;
	bam_pkg::wu_res_t                wu;

	assign cnt      = (ec_q > 11'(bam_pkg::CNT_CAP)) ? 11'(bam_pkg::CNT_CAP) : ec_q;
	assign acc      = in_valid && (state_q == ST_IDLE);
	assign in_ok    = index < 16'(cnt);
	assign in_word  = index[bam_pkg::OFF_W +: AW];
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// read address: the incoming word (word 0 for find), the next scan word, or the held word
	always_comb begin
		case (state_q)
			ST_IDLE: raddr = (command == bam_pkg::CMD_FIND) ? '0 : in_word;
			ST_SCAN: raddr = scan_q + AW'(1);
			default: raddr = waddr_q;
		endcase
	end

	always_comb begin
		base      = BW'({scan_q, bam_pkg::OFF_W'(0)});
		cnt_x     = BW'(cnt);
		rem       = cnt_x - base;
		scan_last = cnt_x <= (base + BW'(bam_pkg::WORD_BITS));
		if (cnt_x <= base) begin
			lim = '0;
		end else if (rem >= BW'(bam_pkg::WORD_BITS)) begin
			lim = (bam_pkg::OFF_W + 1)'(bam_pkg::WORD_BITS);
		end else begin
			lim = rem[bam_pkg::OFF_W:0];
		end
		hit_idx = 11'(base + BW'(wu.zero_pos));
	end

	always_comb begin
		if (state_q == ST_FILL) begin
			we    = 1'b1;
			waddr = scan_q;
			wdata = {bam_pkg::WORD_BITS{fill_val_q}};
		end else begin
			we    = (state_q == ST_WORD) && valid_q &&
			        ((cmd_q == bam_pkg::CMD_SET_ONE) || (cmd_q == bam_pkg::CMD_CLR_ONE));
			waddr = waddr_q;
			wdata = (cmd_q == bam_pkg::CMD_SET_ONE) ? wu.set_word : wu.clr_word;
		end
	end

	bam_ram #(
		.W     (bam_pkg::WORD_BITS),
		.DEPTH (bam_pkg::WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bam_word_unit u_wu (
		.word (rdata),
		.off  (off_q),
		.lim  (lim),
		.res  (wu)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			scan_q      <= '0;
			fill_val_q  <= 1'b0;
			fill_res_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (scan_q == AW'(bam_pkg::WORDS - 1)) begin
						scan_q  <= '0;
						state_q <= fill_res_q ? ST_OUT : ST_IDLE;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						scan_q <= '0;
						case (command)
							bam_pkg::CMD_SET_ALL: begin
								fill_val_q <= 1'b1;
								fill_res_q <= 1'b1;
								state_q    <= ST_FILL;
							end
							bam_pkg::CMD_CLR_ALL: begin
								fill_val_q <= 1'b0;
								fill_res_q <= 1'b1;
								state_q    <= ST_FILL;
							end
							bam_pkg::CMD_SET_ONE,
							bam_pkg::CMD_CLR_ONE,
							bam_pkg::CMD_READ: state_q <= ST_WORD;
							bam_pkg::CMD_FIND: state_q <= ST_SCAN;
							default:           state_q <= ST_OUT;
						endcase
					end
				end
				ST_WORD: state_q <= ST_OUT;
				ST_SCAN: begin
					if (wu.zero_hit || scan_last) begin
						state_q <= ST_OUT;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload and results
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q       <= command;
			off_q       <= index[bam_pkg::OFF_W-1:0];
			waddr_q     <= in_word;
			valid_q     <= in_ok;
			res_bit_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end
		if (state_q == ST_WORD) begin
			res_bit_q <= (cmd_q == bam_pkg::CMD_READ) && valid_q && wu.bit_val;
		end
		if (state_q == ST_SCAN) begin
			if (wu.zero_hit) begin
				res_found_q <= 1'b1;
				res_idx_q   <= hit_idx;
			end else if (scan_last) begin
				res_idx_q <= cnt;
			end
		end
		if (load_out) begin
			out_bit_q    <= res_bit_q;
			out_found_q  <= res_found_q;
			out_idx_q    <= res_idx_q;
			out_ivalid_q <= valid_q;
		end
	end

	// register port
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= 11'd1024;
		end else if (cfg_we) begin
			ec_q <= pwdata[10:0];
		end
	end

	assign prdata      = paddr[2] ? 32'd0 : {21'd0, ec_q};
	assign pready      = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign bit_value   = out_bit_q;
	assign free_found  = out_found_q;
	assign free_index  = out_idx_q;
	assign index_valid = out_ivalid_q;

endmodule

// ===== rtl/bam_checker.sv =====
// Port-level assertions for the allocation bit map, bound to the top level.
module bam_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        bit_value,
	input logic        free_found,
	input logic [10:0] free_index,
	input logic        index_valid
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({bit_value, free_found, free_index, index_valid}))
		else $error("result payload changed while stalled");

	// a transaction in work blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// a set mark can only be reported for an index in range
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_value |-> index_valid)
		else $error("mark reported for out-of-range index");

	// a find result never carries a read mark
	a_find_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && free_found |-> !bit_value)
		else $error("find result with mark set");

endmodule

bind bitmap_allocation_map bam_checker u_bam_checker (.*);

// ===== tb/bitmap_allocation_map_tb.sv =====
// Self-checking testbench for the allocation bit map: directed, count extremes, random.
module bitmap_allocation_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_SPARE_6   = 3'd6;
	localparam logic [2:0] CMD_SPARE_7   = 3'd7;
	localparam logic [2:0] REG_MAP_COUNT = 3'd0;

	typedef struct packed {
		logic        bit_value;
		logic        free_found;
		logic [10:0] free_index;
		logic        index_valid;
	} map_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [15:0] index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        bit_value;
	logic        free_found;
	logic [10:0] free_index;
	logic        index_valid;

	// shadow copy of the block's state
	logic [bam_pkg::MAX_ENTRIES-1:0] marks = '0;
	logic [10:0]                     map_count = 11'd1024;

	map_result_t pending_results[$];
	int          fault_count = 0;
	bit          steady = 1'b0;

	bitmap_allocation_map uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .index(index),
		.out_valid(out_valid), .out_stall(out_stall), .bit_value(bit_value),
		.free_found(free_found), .free_index(free_index), .index_valid(index_valid)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int live_count();
		return (map_count > bam_pkg::MAX_ENTRIES) ? bam_pkg::MAX_ENTRIES : int'(map_count);
	endfunction

	// lowest clear mark below the live count, or the count itself
	function automatic int lowest_clear();
		int lim;
		int pos;
		lim = live_count();
		pos = lim;
		for (int i = lim - 1; i >= 0; i--)
			if (!marks[i])
				pos = i;
		return pos;
	endfunction

	function automatic map_result_t map_apply(input logic [2:0] cmd, input logic [15:0] idx);
		map_result_t r;
		int          lim;
		int          pos;
		r = '0;
		lim = live_count();
		r.index_valid = (int'(idx) < lim);
		case (cmd)
			bam_pkg::CMD_SET_ALL: marks = '1;
			bam_pkg::CMD_CLR_ALL: marks = '0;
			bam_pkg::CMD_SET_ONE: if (r.index_valid) marks[idx] = 1'b1;
			bam_pkg::CMD_CLR_ONE: if (r.index_valid) marks[idx] = 1'b0;
			bam_pkg::CMD_READ: r.bit_value = r.index_valid && marks[idx];
			bam_pkg::CMD_FIND: begin
				pos = lowest_clear();
				r.free_found = (pos < lim);
				r.free_index = pos[10:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fault_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		map_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				$display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
					$time, bit_value, free_found, free_index, index_valid);
			end else begin
				want = pending_results.pop_front();
				check_field("bit_value", want.bit_value, bit_value);
				check_field("free_found", want.free_found, free_found);
				check_field("free_index", want.free_index, free_index);
				check_field("index_valid", want.index_valid, index_valid);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 37);
	end

	task automatic send_op(input logic [2:0] cmd, input logic [15:0] idx);
		while (!steady && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(map_apply(cmd, idx));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write, then read back the count register
	task automatic set_map_count(input logic [10:0] cnt);
		logic [31:0] wd;
		wd = $urandom;
		wd[10:0] = cnt;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAP_COUNT;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		map_count = cnt;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("map count readback", cnt, prdata[10:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [15:0] in_range_index(input int slack);
		int lim;
		lim = live_count();
		return 16'($urandom_range(0, lim + slack - ((lim + slack > 0) ? 1 : 0)));
	endfunction

	task automatic test_directed();
		send_op(bam_pkg::CMD_READ, 16'd0);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_SET_ONE, 16'd0);
		send_op(bam_pkg::CMD_SET_ONE, 16'd1023);
		send_op(bam_pkg::CMD_READ, 16'd1023);
		send_op(bam_pkg::CMD_READ, 16'd1024);
		send_op(bam_pkg::CMD_SET_ONE, 16'd1024);
		send_op(bam_pkg::CMD_SET_ONE, 16'hFFFF);
		send_op(bam_pkg::CMD_CLR_ONE, 16'hFFFF);
		send_op(bam_pkg::CMD_READ, 16'hFFFF);
		send_op(bam_pkg::CMD_FIND, 16'hFFFF);
		send_op(bam_pkg::CMD_SET_ALL, 16'd0);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_CLR_ONE, 16'd1023);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_CLR_ONE, 16'd31);
		send_op(bam_pkg::CMD_CLR_ONE, 16'd32);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_READ, 16'd32);
		send_op(bam_pkg::CMD_READ, 16'd33);
		send_op(bam_pkg::CMD_CLR_ALL, 16'hFFFF);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(CMD_SPARE_6, 16'd5);
		send_op(CMD_SPARE_7, 16'hFFFF);
		send_op(bam_pkg::CMD_READ, 16'd0);
		wait_idle();
	endtask

	task automatic test_count_extremes();
		// zero count: nothing is valid, find reports zero
		set_map_count(11'd0);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_SET_ONE, 16'd0);
		send_op(bam_pkg::CMD_READ, 16'd0);
		send_op(bam_pkg::CMD_CLR_ONE, 16'd0);
		wait_idle();
		set_map_count(11'd1);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_SET_ONE, 16'd0);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_READ, 16'd0);
		send_op(bam_pkg::CMD_READ, 16'd1);
		wait_idle();
		// count above the map size saturates
		set_map_count(11'd2047);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_SET_ALL, 16'd2046);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_CLR_ONE, 16'd1023);
		send_op(bam_pkg::CMD_READ, 16'd1023);
		send_op(bam_pkg::CMD_READ, 16'd1024);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		wait_idle();
		// a set above the count leaves no mark; entries above it show up once the count grows
		set_map_count(11'd8);
		send_op(bam_pkg::CMD_CLR_ALL, 16'd0);
		for (int i = 0; i < 8; i++)
			send_op(bam_pkg::CMD_SET_ONE, 16'(i));
		send_op(bam_pkg::CMD_SET_ONE, 16'd8);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		wait_idle();
		set_map_count(11'd16);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_SET_ALL, 16'd0);
		wait_idle();
		set_map_count(11'd1024);
		send_op(bam_pkg::CMD_FIND, 16'd0);
		send_op(bam_pkg::CMD_READ, 16'd1000);
		wait_idle();
	endtask

	task automatic run_phase(input logic [10:0] cnt, input int quota, input bit calm);
		int sent;
		int pick;
		int pos;
		steady = calm;
		set_map_count(cnt);
		// with 64 or more entries, start near full so searches run long and fail now and then
		if (live_count() >= 64) begin
			send_op(bam_pkg::CMD_SET_ALL, 16'($urandom_range(0, 65535)));
			repeat (8)
				send_op(bam_pkg::CMD_CLR_ONE, in_range_index(0));
		end else begin
			send_op(bam_pkg::CMD_CLR_ALL, 16'($urandom_range(0, 65535)));
		end
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				pos = lowest_clear();
				send_op(bam_pkg::CMD_FIND, in_range_index(2));
				if (pos < live_count())
					send_op(bam_pkg::CMD_SET_ONE, 16'(pos));
				else
					send_op(bam_pkg::CMD_CLR_ONE, in_range_index(0));
				sent += 2;
			end else if (pick < 70) begin
				send_op(bam_pkg::CMD_CLR_ONE, in_range_index(0));
				sent++;
			end else if (pick < 80) begin
				send_op(bam_pkg::CMD_READ, in_range_index(4));
				sent++;
			end else if (pick < 82) begin
				send_op(bam_pkg::CMD_SET_ALL, in_range_index(4));
				sent++;
			end else if (pick < 85) begin
				send_op(bam_pkg::CMD_CLR_ALL, in_range_index(4));
				sent++;
			end else begin
				send_op(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
				sent++;
			end
		end
		wait_idle();
		steady = 1'b0;
	endtask

	task automatic test_random_phases();
		run_phase(11'd1024, 300, 1'b1);
		run_phase(11'd33, 300, 1'b0);
		run_phase(11'd2047, 300, 1'b0);
		run_phase(11'd1, 250, 1'b0);
		run_phase(11'd32, 300, 1'b0);
		run_phase(11'($urandom_range(2, 1023)), 300, 1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_count_extremes();
		test_random_phases();
		wait_idle();
		repeat (40) @(posedge clk);
		if (fault_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
